// ----- sv/ctvlp_pkg.sv -----
// ----------------------------------------------------------------------------
// ctvlp_pkg
// Shared types, codes and literal tables for the CO2/TVOC line parser.
// ----------------------------------------------------------------------------
package ctvlp_pkg;

  // Request kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_CMD  = 2'd2;

  // Sensor status codes
  localparam logic [1:0] ST_NORMAL     = 2'd0;
  localparam logic [1:0] ST_DATA_ERR   = 2'd1;
  localparam logic [1:0] ST_MODULE_ERR = 2'd2;

  localparam logic [7:0] LOSS_LIMIT_RST = 8'd3;

  // Literal lengths
  localparam logic [3:0] LEN_HEAD = 4'd4;
  localparam logic [3:0] LEN_MID  = 4'd9;
  localparam logic [3:0] LEN_END  = 4'd3;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;

  localparam logic [15:0] ACC_MAX = 16'hFFFF;

  typedef enum logic [5:0] {
    PH_HEAD = 6'b000001,
    PH_NUM1 = 6'b000010,
    PH_MID  = 6'b000100,
    PH_NUM2 = 6'b001000,
    PH_END  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  sensor_status;
    logic [15:0] co2_ppm;
    logic [15:0] tvoc_ppb;
    logic        resend_request;
  } out_item_t;

  typedef struct packed {
    logic      hit;
    out_item_t item;
  } ctvlp_res_t;

  // "CO2:"
  function automatic logic [7:0] lit_head_byte(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h4F;
      4'd2:    ch = 8'h32;
      4'd3:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "ppm,TVOS:"
  function automatic logic [7:0] lit_mid_byte(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h70;
      4'd1:    ch = 8'h70;
      4'd2:    ch = 8'h6D;
      4'd3:    ch = 8'h2C;
      4'd4:    ch = 8'h54;
      4'd5:    ch = 8'h56;
      4'd6:    ch = 8'h4F;
      4'd7:    ch = 8'h53;
      4'd8:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "ppd"
  function automatic logic [7:0] lit_end_byte(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h70;
      4'd1:    ch = 8'h70;
      4'd2:    ch = 8'h64;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- sv/ctvlp_parse.sv -----
// ----------------------------------------------------------------------------
// ctvlp_parse
// Parser state and combinational step logic for one request.
// ----------------------------------------------------------------------------
module ctvlp_parse
  import ctvlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  in_item_t   item,
  input  logic [7:0] loss_limit,
  output ctvlp_res_t res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] co2_acc_r, co2_acc_nxt;
  logic [15:0] tvoc_acc_r, tvoc_acc_nxt;
  logic        bad_r, bad_nxt;
  logic        ack_r, ack_nxt;
  logic [1:0]  ackp_r, ackp_nxt;
  logic [7:0]  lost_r, lost_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [15:0] co2_val_r, co2_val_nxt;
  logic [15:0] tvoc_val_r, tvoc_val_nxt;

  logic        is_digit;
  logic [3:0]  midx;
  logic [3:0]  lit_len;
  logic [7:0]  lit_ch;
  logic        lit_hit;
  logic [3:0]  idx_inc;
  logic        lit_done;
  logic [15:0] acc_in;
  logic [19:0] acc_prod;
  logic [15:0] acc_sat;
  logic        do_match;
  phase_t      match_next;
  logic        resend;

  assign is_digit = (item.rx_byte >= CH_ZERO) && (item.rx_byte <= CH_NINE);

  // Literal selection; a digit run ends with the first literal byte at index 0
  always_comb begin
    case (phase_r)
      PH_HEAD: begin
        midx    = idx_r;
        lit_len = LEN_HEAD;
        lit_ch  = lit_head_byte(midx);
      end
      PH_NUM1, PH_MID: begin
        midx    = (phase_r == PH_NUM1) ? 4'd0 : idx_r;
        lit_len = LEN_MID;
        lit_ch  = lit_mid_byte(midx);
      end
      PH_NUM2, PH_END: begin
        midx    = (phase_r == PH_NUM2) ? 4'd0 : idx_r;
        lit_len = LEN_END;
        lit_ch  = lit_end_byte(midx);
      end
      default: begin
        midx    = idx_r;
        lit_len = 4'd0;
        lit_ch  = 8'h00;
      end
    endcase
  end

  assign lit_hit  = (midx < lit_len) && (item.rx_byte == lit_ch);
  assign idx_inc  = midx + 4'd1;
  assign lit_done = (idx_inc == lit_len);

  // Decimal accumulate, saturating
  assign acc_in   = (phase_r == PH_NUM1) ? co2_acc_r : tvoc_acc_r;
  assign acc_prod = {4'd0, acc_in} * 20'd10 + {16'd0, item.rx_byte[3:0]};
  assign acc_sat  = (acc_prod[19:16] != 4'd0) ? ACC_MAX : acc_prod[15:0];

  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    co2_acc_nxt  = co2_acc_r;
    tvoc_acc_nxt = tvoc_acc_r;
    bad_nxt      = bad_r;
    ack_nxt      = ack_r;
    ackp_nxt     = ackp_r;
    lost_nxt     = lost_r;
    status_nxt   = status_r;
    co2_val_nxt  = co2_val_r;
    tvoc_val_nxt = tvoc_val_r;
    do_match     = 1'b0;
    match_next   = PH_DONE;
    resend       = 1'b0;
    res.hit      = 1'b0;

    case (item.kind)
      KIND_TICK: begin
        lost_nxt = lost_r + 8'd1;
        if (lost_nxt == loss_limit) begin
          status_nxt = ST_MODULE_ERR;
          res.hit    = 1'b1;
        end
      end
      KIND_CMD: begin
        ack_nxt      = 1'b1;
        phase_nxt    = PH_HEAD;
        idx_nxt      = 4'd0;
        co2_acc_nxt  = 16'd0;
        tvoc_acc_nxt = 16'd0;
        bad_nxt      = 1'b0;
        ackp_nxt     = 2'd0;
      end
      KIND_BYTE: begin
        if (ack_r) begin
          if (!bad_r && ackp_r != 2'd2) begin
            if (item.rx_byte == ((ackp_r == 2'd0) ? CH_O : CH_K)) begin
              ackp_nxt = ackp_r + 2'd1;
            end else begin
              bad_nxt = 1'b1;
            end
          end
        end else if (!bad_r) begin
          case (phase_r)
            PH_HEAD: begin
              do_match   = 1'b1;
              match_next = PH_NUM1;
            end
            PH_NUM1: begin
              if (is_digit) begin
                co2_acc_nxt = acc_sat;
              end else begin
                phase_nxt  = PH_MID;
                idx_nxt    = 4'd0;
                do_match   = 1'b1;
                match_next = PH_NUM2;
              end
            end
            PH_MID: begin
              do_match   = 1'b1;
              match_next = PH_NUM2;
            end
            PH_NUM2: begin
              if (is_digit) begin
                tvoc_acc_nxt = acc_sat;
              end else begin
                phase_nxt  = PH_END;
                idx_nxt    = 4'd0;
                do_match   = 1'b1;
                match_next = PH_DONE;
              end
            end
            PH_END: begin
              do_match   = 1'b1;
              match_next = PH_DONE;
            end
            PH_DONE: begin
            end
            default: begin
              bad_nxt = 1'b1;
            end
          endcase
          if (do_match) begin
            if (!lit_hit) begin
              bad_nxt = 1'b1;
            end else if (lit_done) begin
              idx_nxt   = 4'd0;
              phase_nxt = match_next;
            end else begin
              idx_nxt = idx_inc;
            end
          end
        end

        // Frame end: judge the frame, then restart parsing
        if (item.frame_last) begin
          lost_nxt = 8'd0;
          res.hit  = 1'b1;
          if (ack_r) begin
            if (!bad_nxt && ackp_nxt == 2'd2) begin
              status_nxt = ST_NORMAL;
              ack_nxt    = 1'b0;
            end else begin
              status_nxt = ST_MODULE_ERR;
              resend     = 1'b1;
            end
          end else if (!bad_nxt && phase_nxt == PH_DONE) begin
            status_nxt   = ST_NORMAL;
            co2_val_nxt  = co2_acc_nxt;
            tvoc_val_nxt = tvoc_acc_nxt;
          end else begin
            status_nxt = ST_DATA_ERR;
          end
          phase_nxt    = PH_HEAD;
          idx_nxt      = 4'd0;
          co2_acc_nxt  = 16'd0;
          tvoc_acc_nxt = 16'd0;
          bad_nxt      = 1'b0;
          ackp_nxt     = 2'd0;
        end
      end
      default: begin
      end
    endcase

    res.item.sensor_status  = status_nxt;
    res.item.co2_ppm        = co2_val_nxt;
    res.item.tvoc_ppb       = tvoc_val_nxt;
    res.item.resend_request = resend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEAD;
      idx_r      <= 4'd0;
      co2_acc_r  <= 16'd0;
      tvoc_acc_r <= 16'd0;
      bad_r      <= 1'b0;
      ack_r      <= 1'b0;
      ackp_r     <= 2'd0;
      lost_r     <= 8'd0;
      status_r   <= ST_MODULE_ERR;
      co2_val_r  <= 16'd0;
      tvoc_val_r <= 16'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      co2_acc_r  <= co2_acc_nxt;
      tvoc_acc_r <= tvoc_acc_nxt;
      bad_r      <= bad_nxt;
      ack_r      <= ack_nxt;
      ackp_r     <= ackp_nxt;
      lost_r     <= lost_nxt;
      status_r   <= status_nxt;
      co2_val_r  <= co2_val_nxt;
      tvoc_val_r <= tvoc_val_nxt;
    end
  end

endmodule

// ----- sv/co2_tvoc_line_parser.sv -----
// ----------------------------------------------------------------------------
// co2_tvoc_line_parser
// Byte-serial parser for CO2/TVOC sensor lines with acknowledge handling.
// ----------------------------------------------------------------------------
// Datapath: the accepted request waits in the input register; when it advances,
//   any result it makes is loaded into the result register, which drives out_valid.
// Throughput: one request per cycle; the input register advances whenever
//   the request makes no result or the output register is free or draining.
// Reset (synchronous, rst_n low): parser at head, data mode, status module
//   error, stored values zero, loss limit 3, both registers empty.
module co2_tvoc_line_parser
  import ctvlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  // Result channel
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  // Configuration: loss limit
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       out_vld_r;
  out_item_t  out_item_r;
  logic [7:0] loss_limit_r;
  ctvlp_res_t res;
  logic       adv;

  // Advance the held request when its result (if any) has a place to go
  assign adv      = in_vld_r && (!res.hit || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  ctvlp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (adv),
    .item       (in_item_r),
    .loss_limit (loss_limit_r),
    .res        (res)
  );

  // Input register: hold the request until it advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  // Result register: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && res.hit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.hit) begin
      out_item_r <= res.item;
    end
  end

  // Loss limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loss_limit_r <= LOSS_LIMIT_RST;
    end else if (cfg_wr_en) begin
      loss_limit_r <= cfg_wr_data;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
